[sv/assert_macros.svh]
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define QAU_ASSERT_IMP(label, clk_i, rst_ni, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked at every clock edge outside reset.
`define QAU_ASSERT_NXT(label, clk_i, rst_ni, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[sv/qau_pkg.sv]
// ----------------------------------------------------------------------------
// qau_pkg
// Command codes and sequencer states of the quaternion attitude unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package qau_pkg;
  typedef enum logic [2:0] {
    CMD_LOAD = 3'd0,
    CMD_POST = 3'd1,
    CMD_PRE  = 3'd2,
    CMD_ROT  = 3'd3,
    CMD_ROTB = 3'd4,
    CMD_CONJ = 3'd5
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ACC  = 5'b00100,
    ST_FIN  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;
endpackage

[sv/quaternion_attitude_unit.sv]
// ----------------------------------------------------------------------------
// quaternion_attitude_unit
// Holds an attitude quaternion; multiplies, conjugates, loads, rotates vectors.
// ----------------------------------------------------------------------------
// One request at a time. Every product goes through one shift-add multiplier
// that takes one multiplier bit per cycle (QUAT_WIDTH bits, or VEC_WIDTH bits
// for the vector pass). The result register is held until taken; the next
// request is taken only after that.
`timescale 1ns / 1ps
module quaternion_attitude_unit #(
  parameter int QUAT_WIDTH = 18,
  parameter int VEC_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic signed [17:0] in_op_w,
  input  logic signed [17:0] in_op_x,
  input  logic signed [17:0] in_op_y,
  input  logic signed [17:0] in_op_z,
  input  logic signed [31:0] in_vec_x,
  input  logic signed [31:0] in_vec_y,
  input  logic signed [31:0] in_vec_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_res_w,
  output logic signed [31:0] out_res_x,
  output logic signed [31:0] out_res_y,
  output logic signed [31:0] out_res_z,
  output logic        out_saturated
);
  import qau_pkg::*;

  localparam int QF  = QUAT_WIDTH - 2;
  // Multiplicand width: matrix elements fit QUAT_WIDTH+4 bits.
  localparam int AW  = QUAT_WIDTH + 4;
  localparam int BW  = (VEC_WIDTH > QUAT_WIDTH) ? VEC_WIDTH : QUAT_WIDTH;
  localparam int PW  = AW + BW;
  localparam int ACW = PW + 4;
  localparam int CW  = $clog2(BW + 1);
  localparam int SW  = 5;

  // Hold attitude, operands, matrix and results.
  logic signed [QUAT_WIDTH-1:0] att_r [4];
  logic signed [QUAT_WIDTH-1:0] op_r [4];
  logic signed [VEC_WIDTH-1:0]  vec_r [3];
  logic signed [AW-1:0]         mat_r [9];
  logic signed [QUAT_WIDTH-1:0] tmp_r [4];
  logic signed [VEC_WIDTH-1:0]  rv_r [3];
  logic [2:0]  cmd_r;
  state_t      st_r, st_nxt;
  logic [SW-1:0] step_r;      // product index in a sum
  logic [4:0]  term_r;        // output term index
  logic [CW-1:0] bit_r;
  logic        phase_r;       // 0 matrix pass, 1 vector pass
  logic signed [PW-1:0] mcand_r;
  logic [BW-1:0]        mplr_r;
  logic                 mneg_r;
  logic signed [PW-1:0] prod_r;
  logic signed [ACW-1:0] acc_r;
  logic        sat_r;
  logic        ov_r;
  logic signed [31:0] res_r [4];

  // Select operands of the current product.
  logic signed [AW-1:0] sel_a;
  logic signed [BW-1:0] sel_b;
  logic                 sel_sub;
  logic [1:0]           nprod;
  logic [CW-1:0]        nbits;
  logic                 is_ham, is_rot;
  logic signed [QUAT_WIDTH-1:0] ha [4], hb [4];
  logic [3:0] mi;
  logic [4:0] sel_term;
  logic [1:0] sel_step;
  logic       sel_phase;
  logic       last_fin, next_fin;

  assign is_ham = (cmd_r == CMD_POST) || (cmd_r == CMD_PRE);
  assign is_rot = (cmd_r == CMD_ROT) || (cmd_r == CMD_ROTB);
  assign nprod  = is_ham ? 2'd3 : (phase_r ? 2'd2 : 2'd1);
  assign nbits  = (is_rot && phase_r) ? CW'(VEC_WIDTH) : CW'(QUAT_WIDTH);

  // Final pass of a sum: store nothing, publish the result.
  assign last_fin = (is_ham && term_r == 5'd4) || (is_rot && phase_r && term_r == 5'd3);
  // Last term stored here; one more pass publishes it.
  assign next_fin = (is_ham && term_r == 5'd3) || (is_rot && phase_r && term_r == 5'd2);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ha[i] = (cmd_r == CMD_PRE) ? op_r[i] : att_r[i];
      hb[i] = (cmd_r == CMD_PRE) ? att_r[i] : op_r[i];
    end
  end

  // Index the product that starts next.
  always_comb begin
    sel_term = term_r;
    sel_step = step_r[1:0] + 2'd1;
    sel_phase = phase_r;
    if (st_r == ST_FIN) begin
      sel_step = 2'd0;
      sel_term = term_r + 5'd1;
      if (is_rot && !phase_r && term_r == 5'd8) begin
        sel_term = 5'd0;
        sel_phase = 1'b1;
      end
    end
  end

  // Pick a*b and sign for term t, product p.
  always_comb begin
    logic [1:0] ia, ib;
    sel_a = '0;
    sel_b = '0;
    sel_sub = 1'b0;
    ia = 2'd0;
    ib = 2'd0;
    mi = 4'd0;
    if (is_ham) begin
      case (sel_term[1:0])
        2'd0: begin
          ia = sel_step; ib = sel_step; sel_sub = (sel_step != 2'd0);
        end
        2'd1: begin
          case (sel_step)
            2'd0: begin ia = 2'd0; ib = 2'd1; end
            2'd1: begin ia = 2'd1; ib = 2'd0; end
            2'd2: begin ia = 2'd2; ib = 2'd3; end
            default: begin ia = 2'd3; ib = 2'd2; sel_sub = 1'b1; end
          endcase
        end
        2'd2: begin
          case (sel_step)
            2'd0: begin ia = 2'd0; ib = 2'd2; end
            2'd1: begin ia = 2'd2; ib = 2'd0; end
            2'd2: begin ia = 2'd3; ib = 2'd1; end
            default: begin ia = 2'd1; ib = 2'd3; sel_sub = 1'b1; end
          endcase
        end
        default: begin
          case (sel_step)
            2'd0: begin ia = 2'd0; ib = 2'd3; end
            2'd1: begin ia = 2'd3; ib = 2'd0; end
            2'd2: begin ia = 2'd1; ib = 2'd2; end
            default: begin ia = 2'd2; ib = 2'd1; sel_sub = 1'b1; end
          endcase
        end
      endcase
      sel_a = AW'(ha[ia]);
      sel_b = BW'(hb[ib]);
    end else if (!sel_phase) begin
      case (sel_term[3:0])
        4'd0: begin ia = 2'd0; ib = 2'd0; end
        4'd4: begin ia = 2'd0; ib = 2'd0; end
        4'd8: begin ia = 2'd0; ib = 2'd0; end
        4'd1, 4'd3: begin ia = 2'd1; ib = 2'd2; end
        4'd2, 4'd6: begin ia = 2'd1; ib = 2'd3; end
        default: begin ia = 2'd2; ib = 2'd3; end
      endcase
      if (sel_step[0]) begin
        case (sel_term[3:0])
          4'd0: begin ia = 2'd1; ib = 2'd1; end
          4'd4: begin ia = 2'd2; ib = 2'd2; end
          4'd8: begin ia = 2'd3; ib = 2'd3; end
          4'd1: begin ia = 2'd0; ib = 2'd3; sel_sub = 1'b1; end
          4'd3: begin ia = 2'd0; ib = 2'd3; end
          4'd2: begin ia = 2'd0; ib = 2'd2; end
          4'd6: begin ia = 2'd0; ib = 2'd2; sel_sub = 1'b1; end
          4'd5: begin ia = 2'd0; ib = 2'd1; sel_sub = 1'b1; end
          default: begin ia = 2'd0; ib = 2'd1; end
        endcase
      end
      sel_a = AW'(att_r[ia]);
      sel_b = BW'(att_r[ib]);
    end else begin
      if (cmd_r == CMD_ROTB) mi = 4'(sel_step * 3 + sel_term[1:0]);
      else mi = 4'(sel_term[1:0] * 3 + sel_step);
      sel_a = mat_r[mi];
      sel_b = BW'(vec_r[sel_step]);
    end
  end

  // Saturate accumulator (after shift) to QUAT_WIDTH or VEC_WIDTH; matrix elements are truncated to AW bits.
  logic signed [ACW-1:0] shd;
  logic signed [QUAT_WIDTH-1:0] qclip;
  logic signed [VEC_WIDTH-1:0]  vclip;
  logic signed [AW-1:0]         mclip;
  logic qhit, vhit;
  logic signed [ACW-1:0] dacc;
  assign dacc = (!phase_r && is_rot) ?
      ((acc_r <<< 1) - (ACW'(1) <<< (2 * QF)) * ACW'(term_r[3:0] == 4'd0 ||
        term_r[3:0] == 4'd4 || term_r[3:0] == 4'd8)) : acc_r;
  assign shd = dacc >>> QF;
  always_comb begin
    qhit = (shd > ACW'((1 <<< (QUAT_WIDTH - 1)) - 1)) ||
           (shd < -(ACW'(1) <<< (QUAT_WIDTH - 1)));
    qclip = shd[QUAT_WIDTH-1:0];
    if (qhit) qclip = shd[ACW-1] ? {1'b1, {(QUAT_WIDTH-1){1'b0}}}
                                 : {1'b0, {(QUAT_WIDTH-1){1'b1}}};
    vhit = (shd > ((ACW'(1) <<< (VEC_WIDTH - 1)) - 1)) ||
           (shd < -(ACW'(1) <<< (VEC_WIDTH - 1)));
    vclip = shd[VEC_WIDTH-1:0];
    if (vhit) vclip = shd[ACW-1] ? {1'b1, {(VEC_WIDTH-1){1'b0}}}
                                 : {1'b0, {(VEC_WIDTH-1){1'b1}}};
    mclip = shd[AW-1:0];
  end

  // Conjugate negation with clip.
  logic signed [QUAT_WIDTH:0] cneg [4];
  logic signed [QUAT_WIDTH-1:0] cres [4];
  logic chit;
  always_comb begin
    chit = 1'b0;
    cres[0] = att_r[0];
    cneg[0] = '0;
    for (int i = 1; i < 4; i++) begin
      cneg[i] = -{att_r[i][QUAT_WIDTH-1], att_r[i]};
      cres[i] = cneg[i][QUAT_WIDTH-1:0];
      if (cneg[i][QUAT_WIDTH] != cneg[i][QUAT_WIDTH-1]) begin
        cres[i] = {1'b0, {(QUAT_WIDTH-1){1'b1}}};
        chit = 1'b1;
      end
    end
  end

  assign in_stall  = (st_r != ST_IDLE);
  assign out_valid = (st_r == ST_OUT);
  assign out_res_w = res_r[0];
  assign out_res_x = res_r[1];
  assign out_res_y = res_r[2];
  assign out_res_z = res_r[3];
  assign out_saturated = ov_r;

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_valid) st_nxt = ST_FIN;
      ST_MUL:  if (bit_r == nbits - CW'(1)) st_nxt = ST_ACC;
      ST_ACC:  if (step_r[1:0] == nprod) st_nxt = ST_FIN;
               else st_nxt = ST_MUL;
      ST_FIN: begin
        if ((!is_ham && !is_rot) || last_fin) st_nxt = ST_OUT;
        else if (next_fin) st_nxt = ST_FIN;
        else st_nxt = ST_MUL;
      end
      ST_OUT:  if (!out_stall) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      att_r[0] <= QUAT_WIDTH'(1 <<< QF);
      att_r[1] <= '0;
      att_r[2] <= '0;
      att_r[3] <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_FIN) begin
        if (cmd_r == CMD_LOAD) att_r <= op_r;
        else if (cmd_r == CMD_CONJ) att_r <= cres;
        else if (is_ham && term_r == 5'd4) att_r <= tmp_r;
      end
    end
  end

  // Datapath: bit-serial shift-add multiplier and accumulator.
  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        cmd_r <= in_cmd;
        op_r[0] <= QUAT_WIDTH'(in_op_w);
        op_r[1] <= QUAT_WIDTH'(in_op_x);
        op_r[2] <= QUAT_WIDTH'(in_op_y);
        op_r[3] <= QUAT_WIDTH'(in_op_z);
        vec_r[0] <= VEC_WIDTH'(in_vec_x);
        vec_r[1] <= VEC_WIDTH'(in_vec_y);
        vec_r[2] <= VEC_WIDTH'(in_vec_z);
        step_r <= '0;
        phase_r <= 1'b0;
        sat_r <= 1'b0;
        acc_r <= '0;
        bit_r <= '0;
        prod_r <= '0;
        // First state after capture is FIN, which primes the first product.
        term_r <= 5'h1f;
      end
      ST_MUL: begin
        if (mplr_r[0]) prod_r <= prod_r + mcand_r;
        mcand_r <= mcand_r <<< 1;
        mplr_r <= mplr_r >> 1;
        bit_r <= bit_r + CW'(1);
      end
      ST_ACC: begin
        if (mneg_r) acc_r <= acc_r - ACW'(prod_r);
        else acc_r <= acc_r + ACW'(prod_r);
        step_r <= step_r + SW'(1);
        // Prime the next product of this sum.
        if (step_r[1:0] != nprod) begin
          bit_r <= '0;
          prod_r <= '0;
        end
      end
      ST_FIN: begin
        // Store the finished term (term_r of all ones means none yet).
        if (term_r != 5'h1f && !last_fin) begin
          if (is_ham) begin
            tmp_r[term_r[1:0]] <= qclip;
            sat_r <= sat_r | qhit;
          end else if (!phase_r) begin
            mat_r[term_r[3:0]] <= mclip;
          end else begin
            rv_r[term_r[1:0]] <= vclip;
            sat_r <= sat_r | vhit;
          end
        end
        acc_r <= '0;
        step_r <= '0;
        bit_r <= '0;
        prod_r <= '0;
        if (is_rot && !phase_r && term_r == 5'd8) begin
          phase_r <= 1'b1;
          term_r <= '0;
        end else begin
          term_r <= term_r + 5'd1;
        end
        // Results.
        if (!is_ham && !is_rot) begin
          for (int i = 0; i < 4; i++)
            res_r[i] <= 32'(signed'(cmd_r == CMD_LOAD ? op_r[i] :
                                    cmd_r == CMD_CONJ ? cres[i] : att_r[i]));
          ov_r <= (cmd_r == CMD_CONJ) && chit;
        end else if (is_ham) begin
          for (int i = 0; i < 4; i++) res_r[i] <= 32'(signed'(tmp_r[i]));
          ov_r <= sat_r;
        end else begin
          res_r[0] <= '0;
          for (int i = 0; i < 3; i++) res_r[i+1] <= 32'(signed'(rv_r[i]));
          ov_r <= sat_r;
        end
      end
      default: ;
    endcase
    // Load multiplier operands whenever a product starts.
    if ((st_r == ST_FIN || st_r == ST_ACC) && st_nxt == ST_MUL) begin
      mcand_r <= PW'(sel_a);
      mplr_r  <= sel_b[BW-1] ? BW'(-sel_b) : BW'(sel_b);
      mneg_r  <= sel_b[BW-1] ^ sel_sub;
    end
  end
endmodule

[sv/qau_checker.sv]
// ----------------------------------------------------------------------------
// qau_checker
// Port-level checks of the quaternion attitude unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module qau_port_props (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_saturated
);
  // One request in flight: no acceptance while a result waits.
  `QAU_ASSERT_IMP(a_one_flight, clk, rst_n, out_valid, in_stall)
  // A stalled result holds.
  `QAU_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid)
  // Flag stays stable while stalled.
  `QAU_ASSERT_NXT(a_flag, clk, rst_n, out_valid && out_stall, $stable(out_saturated))
endmodule

bind quaternion_attitude_unit qau_port_props u_qau_port_props (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_saturated(out_saturated)
);

[verif/qau_checker.sv]
// ----------------------------------------------------------------------------
// qau_checker
// Watches both channels of the quaternion attitude unit, predicts each result
// from its own copy of the attitude and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module qau_checker
  import qau_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         in_cmd,
  input  logic signed [17:0] in_op_w,
  input  logic signed [17:0] in_op_x,
  input  logic signed [17:0] in_op_y,
  input  logic signed [17:0] in_op_z,
  input  logic signed [31:0] in_vec_x,
  input  logic signed [31:0] in_vec_y,
  input  logic signed [31:0] in_vec_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_res_w,
  input  logic signed [31:0] out_res_x,
  input  logic signed [31:0] out_res_y,
  input  logic signed [31:0] out_res_z,
  input  logic               out_saturated,
  output int                 fails,
  output int                 pending
);
  localparam int QW   = 18;
  localparam int FRAC = 16;

  typedef struct {
    logic [31:0] w;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        sat;
  } attitude_result_t;

  attitude_result_t expected_results[$];
  longint att[4];

  // Clip to the signed range of w bits, flag when clipped.
  function automatic longint clamp(longint v, int w, inout bit hit);
    longint lim;
    lim = (longint'(1) << (w - 1)) - 1;
    if (v > lim) begin
      hit = 1'b1;
      return lim;
    end
    if (v < -lim - 1) begin
      hit = 1'b1;
      return -lim - 1;
    end
    return v;
  endfunction

  // Hamilton product a * b, each sum floored to the quaternion fraction and clipped to QW bits.
  function automatic void hamilton(input longint a[4], input longint b[4],
                                   output longint r[4], inout bit hit);
    r[0] = clamp((a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]) >>> FRAC, QW, hit);
    r[1] = clamp((a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2]) >>> FRAC, QW, hit);
    r[2] = clamp((a[0]*b[2] + a[2]*b[0] + a[3]*b[1] - a[1]*b[3]) >>> FRAC, QW, hit);
    r[3] = clamp((a[0]*b[3] + a[3]*b[0] + a[1]*b[2] - a[2]*b[1]) >>> FRAC, QW, hit);
  endfunction

  // Rotation matrix element 2*(a*b + s*c*d) minus one on the diagonal.
  function automatic longint mat_elem(longint a, longint b, longint c, longint d,
                                      int s, bit diag);
    longint acc;
    acc = 2 * (a * b + s * c * d);
    if (diag) acc = acc - (longint'(1) << (2 * FRAC));
    return acc >>> FRAC;
  endfunction

  // Advance the attitude by one request and return what it yields.
  function automatic attitude_result_t attitude_step(logic [2:0] cmd, longint op[4],
                                                     longint v[3]);
    attitude_result_t res;
    longint tmp[4];
    longint m[3][3];
    longint r[3];
    longint acc;
    bit hit;
    hit = 1'b0;
    case (cmd)
      CMD_LOAD: att = op;
      CMD_POST: begin
        hamilton(att, op, tmp, hit);
        att = tmp;
      end
      CMD_PRE: begin
        hamilton(op, att, tmp, hit);
        att = tmp;
      end
      CMD_CONJ: begin
        for (int i = 1; i < 4; i++) att[i] = clamp(-att[i], QW, hit);
      end
      default: ;
    endcase
    if (cmd == CMD_ROT || cmd == CMD_ROTB) begin
      m[0][0] = mat_elem(att[0], att[0], att[1], att[1], 1, 1'b1);
      m[0][1] = mat_elem(att[1], att[2], att[0], att[3], -1, 1'b0);
      m[0][2] = mat_elem(att[1], att[3], att[0], att[2], 1, 1'b0);
      m[1][0] = mat_elem(att[1], att[2], att[0], att[3], 1, 1'b0);
      m[1][1] = mat_elem(att[0], att[0], att[2], att[2], 1, 1'b1);
      m[1][2] = mat_elem(att[2], att[3], att[0], att[1], -1, 1'b0);
      m[2][0] = mat_elem(att[1], att[3], att[0], att[2], -1, 1'b0);
      m[2][1] = mat_elem(att[2], att[3], att[0], att[1], 1, 1'b0);
      m[2][2] = mat_elem(att[0], att[0], att[3], att[3], 1, 1'b1);
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++)
          acc += (cmd == CMD_ROTB ? m[j][i] : m[i][j]) * v[j];
        r[i] = clamp(acc >>> FRAC, 32, hit);
      end
      res.w = '0;
      res.x = r[0][31:0];
      res.y = r[1][31:0];
      res.z = r[2][31:0];
    end else begin
      res.w = att[0][31:0];
      res.x = att[1][31:0];
      res.y = att[2][31:0];
      res.z = att[3][31:0];
    end
    res.sat = hit;
    return res;
  endfunction

  // Print one mismatch and count it.
  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
    fails++;
  endtask

  initial begin
    fails = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    attitude_result_t e;
    longint op[4];
    longint v[3];
    if (!rst_n) begin
      att = '{longint'(1) << FRAC, 0, 0, 0};
      expected_results.delete();
    end else begin
      // Predict each accepted request.
      if (in_valid && !in_stall) begin
        op = '{longint'(in_op_w), longint'(in_op_x), longint'(in_op_y), longint'(in_op_z)};
        v = '{longint'(in_vec_x), longint'(in_vec_y), longint'(in_vec_z)};
        expected_results.push_back(attitude_step(in_cmd, op, v));
      end
      // Compare each accepted result with the oldest prediction.
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report("unexpected result w", out_res_w, '0);
        end else begin
          e = expected_results.pop_front();
          if (out_res_w !== e.w) report("res_w", out_res_w, e.w);
          if (out_res_x !== e.x) report("res_x", out_res_x, e.x);
          if (out_res_y !== e.y) report("res_y", out_res_y, e.y);
          if (out_res_z !== e.z) report("res_z", out_res_z, e.z);
          if (out_saturated !== e.sat) report("saturated", 32'(out_saturated), 32'(e.sat));
        end
      end
    end
    pending = expected_results.size();
  end
endmodule

[verif/quaternion_attitude_unit_tb.sv]
// ----------------------------------------------------------------------------
// quaternion_attitude_unit_tb
// Drives directed and random attitude requests with random idling on both
// channels; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module quaternion_attitude_unit_tb;
  import qau_pkg::*;

  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam logic signed [17:0] Q_MAX = 18'sh1FFFF;
  localparam logic signed [17:0] Q_MIN = -18'sh20000;
  localparam logic signed [17:0] Q_ONE = 18'sh10000;
  localparam logic signed [31:0] V_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] V_MIN = -32'sh80000000;
  localparam int N_RANDOM = 1880;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_cmd = '0;
  logic signed [17:0] in_op_w = '0, in_op_x = '0, in_op_y = '0, in_op_z = '0;
  logic signed [31:0] in_vec_x = '0, in_vec_y = '0, in_vec_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_res_w, out_res_x, out_res_y, out_res_z;
  logic out_saturated;
  int fails;
  int pending;
  bit hold_long = 1'b0;
  bit no_gaps = 1'b0;

  always #5 clk = ~clk;

  quaternion_attitude_unit dut (.*);

  qau_checker chk (.*);

  // End the run if it hangs.
  initial begin
    #200_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [17:0] rand_quat();
    case ($urandom_range(0, 5))
      0: return 18'($urandom);
      1: return Q_MAX;
      2: return Q_MIN;
      default: return 18'($signed($urandom_range(0, 2 * 46341)) - 46341);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_vec();
    case ($urandom_range(0, 5))
      0, 1: return 32'($urandom);
      2: return $urandom_range(0, 1) ? V_MAX : V_MIN;
      default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endcase
  endfunction

  // Offer one request until it is taken, then idle at random.
  task automatic send(logic [2:0] cmd, logic signed [17:0] w, logic signed [17:0] x,
                      logic signed [17:0] y, logic signed [17:0] z,
                      logic signed [31:0] vx, logic signed [31:0] vy,
                      logic signed [31:0] vz);
    int g;
    in_cmd = cmd;
    in_op_w = w; in_op_x = x; in_op_y = y; in_op_z = z;
    in_vec_x = vx; in_vec_y = vy; in_vec_z = vz;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic send_random();
    logic [2:0] cmd;
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) cmd = CMD_LOAD;
    else if (r < 33) cmd = CMD_POST;
    else if (r < 50) cmd = CMD_PRE;
    else if (r < 70) cmd = CMD_ROT;
    else if (r < 88) cmd = CMD_ROTB;
    else if (r < 96) cmd = CMD_CONJ;
    else cmd = $urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI;
    send(cmd, rand_quat(), rand_quat(), rand_quat(), rand_quat(),
         rand_vec(), rand_vec(), rand_vec());
  endtask

  // Stall results at random; hold off a long stretch on request.
  initial begin
    int r;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_stall = 1'b1;
        repeat (1500) @(negedge clk);
        hold_long = 1'b0;
      end else if (no_gaps) begin
        out_stall = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) out_stall = 1'b0;
        else if (r < 97) out_stall = 1'b1;
        else begin
          out_stall = 1'b1;
          repeat ($urandom_range(10, 80)) @(negedge clk);
        end
      end
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: identity rotation, extremes, every command, spare codes.
    send(CMD_ROT, 0, 0, 0, 0, V_MAX, V_MIN, 32'sd65536);
    send(CMD_ROTB, 0, 0, 0, 0, V_MIN, V_MAX, -32'sd1);
    send(CMD_SPARE_LO, 0, 0, 0, 0, 0, 0, 0);
    send(CMD_LOAD, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 0, 0, 0);
    send(CMD_CONJ, 0, 0, 0, 0, 0, 0, 0);
    send(CMD_CONJ, 0, 0, 0, 0, 0, 0, 0);
    send(CMD_POST, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0, 0, 0);
    send(CMD_LOAD, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0);
    send(CMD_PRE, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0);
    send(CMD_ROT, 0, 0, 0, 0, V_MAX, V_MAX, V_MAX);
    send(CMD_LOAD, 18'sd46341, 0, 0, 18'sd46341, 0, 0, 0);
    send(CMD_ROT, 0, 0, 0, 0, 32'sd65536, 32'sd131072, -32'sd65536);
    send(CMD_ROTB, 0, 0, 0, 0, 32'sd65536, 32'sd131072, -32'sd65536);
    send(CMD_POST, 18'sd46341, 18'sd46341, 0, 0, 0, 0, 0);
    send(CMD_PRE, 0, 0, Q_ONE, 0, 0, 0, 0);
    send(CMD_SPARE_HI, Q_MAX, Q_MAX, Q_MAX, Q_MAX, V_MAX, V_MAX, V_MAX);
    send(CMD_LOAD, Q_ONE, 0, 0, 0, 0, 0, 0);
    send(CMD_ROT, 0, 0, 0, 0, V_MIN, V_MIN, V_MIN);

    // Random, with phases of no idling, long receiver holds and periodic drains.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) no_gaps = 1'b1;
      if (i == 400) no_gaps = 1'b0;
      if (i == 600 || i == 1400) hold_long = 1'b1;
      if (i % 250 == 249) begin
        in_valid = 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
      send_random();
    end
    in_valid = 1'b0;

    wait (pending == 0);
    repeat (50) @(negedge clk);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
